### sv/btpm_pkg.sv
`timescale 1ns / 1ps
package btpm_pkg;

   localparam int ADDR_BITS = 32;
   localparam int MAX_NODES = 4096;
   localparam int NODE_BITS = $clog2(MAX_NODES);
   localparam int USED_BITS = $clog2(MAX_NODES + 1);
   localparam int MISS_BITS = $clog2(ADDR_BITS + 1);
   localparam int HOP_BITS  = 32;
   localparam int PORT_BITS = 4;

   typedef enum logic {
      CMD_INSERT = 1'b0,
      CMD_LOOKUP = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_OK   = 2'd0,
      STATUS_MISS = 2'd1,
      STATUS_FULL = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WALK,
      ST_COUNT,
      ST_CHECK,
      ST_ALLOC,
      ST_STORE,
      ST_RESULT
   } engine_state_type;

   // one trie node as held in the node store
   typedef struct packed {
      logic [NODE_BITS-1:0] child_low;
      logic [NODE_BITS-1:0] child_high;
      logic                 route_here;
      logic [HOP_BITS-1:0]  hop;
      logic [PORT_BITS-1:0] port;
   } node_word_type;

   // classified request handed from front to back
   typedef struct packed {
      cmd_type              cmd;
      logic [ADDR_BITS-1:0] address;
      logic [ADDR_BITS-1:0] walk_mask;
      logic [HOP_BITS-1:0]  hop;
      logic [PORT_BITS-1:0] port;
   } req_item_type;

endpackage

### sv/binary_trie_prefix_match_core.sv
`timescale 1ns / 1ps
// channel   | handshake         | payload
// ----------+-------------------+---------------------------------------------------
// request   | req_push/req_full | req_cmd req_address req_prefix_mask
//           |                   | req_hop_address req_out_port
// response  | rsp_pop/rsp_empty | rsp_status rsp_found_hop rsp_found_port
//
// lookup: walks d trie levels (up to 32), one node-store read per level
// insert: walks the existing nodes; when m nodes are missing it counts and allocates them
// (counting and allocation step one level per cycle), or is refused as full if fewer than m are free
// reset clears the root node and sets the fill count to one, for the root; deeper nodes are written
// when they are allocated, so no clearing pass runs
// a two-request queue and a response register let either side stall independently
module binary_trie_prefix_match_core
   import btpm_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  logic                 req_cmd,
   input  logic [ADDR_BITS-1:0] req_address,
   input  logic [ADDR_BITS-1:0] req_prefix_mask,
   input  logic [HOP_BITS-1:0]  req_hop_address,
   input  logic [PORT_BITS-1:0] req_out_port,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output logic [1:0]           rsp_status,
   output logic [HOP_BITS-1:0]  rsp_found_hop,
   output logic [PORT_BITS-1:0] rsp_found_port
);

   logic         q_valid;
   logic         q_pop;
   req_item_type q_item;

   btpm_front front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_cmd         (req_cmd),
      .req_address     (req_address),
      .req_prefix_mask (req_prefix_mask),
      .req_hop_address (req_hop_address),
      .req_out_port    (req_out_port),
      .q_valid         (q_valid),
      .q_item          (q_item),
      .q_pop           (q_pop)
   );

   btpm_engine engine (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_valid),
      .q_item         (q_item),
      .q_pop          (q_pop),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_status     (rsp_status),
      .rsp_found_hop  (rsp_found_hop),
      .rsp_found_port (rsp_found_port)
   );

   // the back end only takes a request that the queue holds
   assert property (@(posedge clock) disable iff (reset) q_pop |-> q_valid)
      else $error("engine popped an empty request queue");

   // a miss or a refused insert carries no route
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_status != STATUS_OK) |-> (rsp_found_hop == '0 && rsp_found_port == '0))
      else $error("non-hit response carries route data");

   assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_status == STATUS_OK || rsp_status == STATUS_MISS
                      || rsp_status == STATUS_FULL))
      else $error("undefined response status");

   // reset leaves both queues empty
   assert property (@(posedge clock) $past(reset) |-> (rsp_empty && !req_full))
      else $error("queues not empty after reset");

endmodule

### sv/btpm_ram.sv
`timescale 1ns / 1ps
module btpm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

### sv/btpm_front.sv
`timescale 1ns / 1ps
module btpm_front
   import btpm_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  logic                 req_cmd,
   input  logic [ADDR_BITS-1:0] req_address,
   input  logic [ADDR_BITS-1:0] req_prefix_mask,
   input  logic [HOP_BITS-1:0]  req_hop_address,
   input  logic [PORT_BITS-1:0] req_out_port,
   output logic                 q_valid,
   output req_item_type         q_item,
   input  logic                 q_pop
);

   localparam int QUEUE_DEPTH = 2;

   req_item_type entries_ff [QUEUE_DEPTH];
   req_item_type item_in;
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;
   logic         do_push, do_pop;

   assign req_full = (count_ff == 2'(QUEUE_DEPTH));
   assign q_valid  = (count_ff != 2'd0);
   assign q_item   = entries_ff[rd_ptr_ff];
   assign do_push  = req_push && !req_full;
   assign do_pop   = q_pop && q_valid;

   always_comb begin
      item_in.cmd     = cmd_type'(req_cmd);
      item_in.address = req_address;
      // a lookup walks every address bit; an insert stops at the first zero of its mask
      item_in.walk_mask = (cmd_type'(req_cmd) == CMD_LOOKUP) ? '1 : req_prefix_mask;
      item_in.hop     = req_hop_address;
      item_in.port    = req_out_port;
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= item_in;
      end
   end

endmodule

### sv/btpm_engine.sv
`timescale 1ns / 1ps
module btpm_engine
   import btpm_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_valid,
   input  req_item_type         q_item,
   output logic                 q_pop,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output logic [1:0]           rsp_status,
   output logic [HOP_BITS-1:0]  rsp_found_hop,
   output logic [PORT_BITS-1:0] rsp_found_port
);

   engine_state_type     state_ff, state_in;
   cmd_type              cmd_ff, cmd_in;
   logic [ADDR_BITS-1:0] addr_ff, addr_in;
   logic [ADDR_BITS-1:0] mask_ff, mask_in;
   logic [ADDR_BITS-1:0] cmask_ff, cmask_in;
   logic [HOP_BITS-1:0]  hop_ff, hop_in;
   logic [PORT_BITS-1:0] port_ff, port_in;
   logic [NODE_BITS-1:0] node_ff, node_in;
   logic                 at_root_ff, at_root_in;
   node_word_type        word_ff, word_in;
   node_word_type        root_ff, root_in;
   logic [USED_BITS-1:0] nodes_used_ff, nodes_used_in;
   logic                 hit_ff, hit_in;
   logic [HOP_BITS-1:0]  best_hop_ff, best_hop_in;
   logic [PORT_BITS-1:0] best_port_ff, best_port_in;
   logic [MISS_BITS-1:0] missing_ff, missing_in;
   status_type           status_ff, status_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   status_type           rsp_status_ff, rsp_status_in;
   logic [HOP_BITS-1:0]  rsp_hop_ff, rsp_hop_in;
   logic [PORT_BITS-1:0] rsp_port_ff, rsp_port_in;

   logic                 ram_wr_en, ram_rd_en;
   logic [NODE_BITS-1:0] ram_wr_addr, ram_rd_addr;
   node_word_type        ram_wr_data;
   logic [$bits(node_word_type)-1:0] ram_rd_data;

   node_word_type        cur_word, upd_word;
   logic [NODE_BITS-1:0] next_node;
   logic [USED_BITS-1:0] free_nodes;
   logic                 addr_bit, slot_free;

   btpm_ram #(
      .WIDTH($bits(node_word_type)),
      .DEPTH(MAX_NODES)
   ) node_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rsp_empty      = !rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_found_hop  = rsp_hop_ff;
   assign rsp_found_port = rsp_port_ff;

   // root lives in flops; every other node is written when it is allocated
   assign cur_word   = at_root_ff ? root_ff : node_word_type'(ram_rd_data);
   assign addr_bit   = addr_ff[ADDR_BITS-1];
   assign next_node  = addr_bit ? cur_word.child_high : cur_word.child_low;
   assign free_nodes = USED_BITS'(MAX_NODES) - nodes_used_ff;
   assign slot_free  = !rsp_valid_ff || rsp_pop;

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      addr_in       = addr_ff;
      mask_in       = mask_ff;
      cmask_in      = cmask_ff;
      hop_in        = hop_ff;
      port_in       = port_ff;
      node_in       = node_ff;
      at_root_in    = at_root_ff;
      word_in       = word_ff;
      root_in       = root_ff;
      nodes_used_in = nodes_used_ff;
      hit_in        = hit_ff;
      best_hop_in   = best_hop_ff;
      best_port_in  = best_port_ff;
      missing_in    = missing_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_pop;
      rsp_status_in = rsp_status_ff;
      rsp_hop_in    = rsp_hop_ff;
      rsp_port_in   = rsp_port_ff;
      q_pop         = 1'b0;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = node_ff;
      ram_wr_data   = word_ff;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = next_node;
      upd_word      = word_ff;

      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop      = 1'b1;
               cmd_in     = q_item.cmd;
               addr_in    = q_item.address;
               mask_in    = q_item.walk_mask;
               hop_in     = q_item.hop;
               port_in    = q_item.port;
               node_in    = '0;
               at_root_in = 1'b1;
               hit_in     = 1'b0;
               status_in  = STATUS_OK;
               state_in   = ST_WALK;
            end
         end

         ST_WALK: begin
            // deepest route on the path wins
            if (cur_word.route_here) begin
               hit_in       = 1'b1;
               best_hop_in  = cur_word.hop;
               best_port_in = cur_word.port;
            end
            if (!mask_ff[ADDR_BITS-1]) begin
               word_in  = cur_word;
               state_in = (cmd_ff == CMD_INSERT) ? ST_STORE : ST_RESULT;
            end else if (next_node == '0) begin
               word_in    = cur_word;
               cmask_in   = mask_ff;
               missing_in = '0;
               state_in   = (cmd_ff == CMD_INSERT) ? ST_COUNT : ST_RESULT;
            end else begin
               ram_rd_en  = 1'b1;
               node_in    = next_node;
               at_root_in = 1'b0;
               addr_in    = addr_ff << 1;
               mask_in    = mask_ff << 1;
            end
         end

         ST_COUNT: begin
            // remaining leading ones of the mask are the nodes still to allocate
            if (cmask_ff[ADDR_BITS-1]) begin
               missing_in = missing_ff + 1'b1;
               cmask_in   = cmask_ff << 1;
            end else begin
               state_in = ST_CHECK;
            end
         end

         ST_CHECK: begin
            if (USED_BITS'(missing_ff) > free_nodes) begin
               status_in = STATUS_FULL;
               state_in  = ST_RESULT;
            end else begin
               state_in = ST_ALLOC;
            end
         end

         ST_ALLOC: begin
            if (mask_ff[ADDR_BITS-1]) begin
               if (addr_bit) begin
                  upd_word.child_high = nodes_used_ff[NODE_BITS-1:0];
               end else begin
                  upd_word.child_low = nodes_used_ff[NODE_BITS-1:0];
               end
               if (at_root_ff) begin
                  root_in = upd_word;
               end else begin
                  ram_wr_en   = 1'b1;
                  ram_wr_data = upd_word;
               end
               word_in       = '0;
               node_in       = nodes_used_ff[NODE_BITS-1:0];
               at_root_in    = 1'b0;
               nodes_used_in = nodes_used_ff + 1'b1;
               addr_in       = addr_ff << 1;
               mask_in       = mask_ff << 1;
            end else begin
               state_in = ST_STORE;
            end
         end

         ST_STORE: begin
            upd_word.route_here = 1'b1;
            upd_word.hop        = hop_ff;
            upd_word.port       = port_ff;
            if (at_root_ff) begin
               root_in = upd_word;
            end else begin
               ram_wr_en   = 1'b1;
               ram_wr_data = upd_word;
            end
            status_in = STATUS_OK;
            state_in  = ST_RESULT;
         end

         ST_RESULT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               if (cmd_ff == CMD_LOOKUP && hit_ff) begin
                  rsp_status_in = STATUS_OK;
                  rsp_hop_in    = best_hop_ff;
                  rsp_port_in   = best_port_ff;
               end else begin
                  rsp_status_in = (cmd_ff == CMD_LOOKUP) ? STATUS_MISS : status_ff;
                  rsp_hop_in    = '0;
                  rsp_port_in   = '0;
               end
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         root_ff       <= '0;
         nodes_used_ff <= USED_BITS'(1);
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         root_ff       <= root_in;
         nodes_used_ff <= nodes_used_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      addr_ff       <= addr_in;
      mask_ff       <= mask_in;
      cmask_ff      <= cmask_in;
      hop_ff        <= hop_in;
      port_ff       <= port_in;
      node_ff       <= node_in;
      at_root_ff    <= at_root_in;
      word_ff       <= word_in;
      hit_ff        <= hit_in;
      best_hop_ff   <= best_hop_in;
      best_port_ff  <= best_port_in;
      missing_ff    <= missing_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_hop_ff    <= rsp_hop_in;
      rsp_port_ff   <= rsp_port_in;
   end

endmodule
